// File: rtl/clfe_pkg.sv
// Shared types, constants and header lookup for the content-length frame extractor.
// Used by clfe_parser and content_length_frame_extractor; depends on nothing.
package clfe_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 20;   // frame length and limit width
   localparam int unsigned ACC_W  = 24;   // length accumulator width
   localparam int unsigned HDR_LEN = 15;
   localparam int unsigned POS_W  = 4;

   localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = LEN_W'(100000);
   localparam logic [ACC_W-1:0]  ACC_SAT = {ACC_W{1'b1}};
   // accumulator bound above which acc*10+d would pass saturation
   localparam logic [ACC_W-1:0]  ACC_LIM_LO = ACC_W'((24'hFFFFFF - 5) / 10); // digits 0..5
   localparam logic [ACC_W-1:0]  ACC_LIM_HI = ACC_W'((24'hFFFFFF - 9) / 10); // digits 6..9
   localparam logic [POS_W-1:0]  HDR_LAST_POS = POS_W'(HDR_LEN - 1);

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PS_HEADER  = 3'd0,
      PS_DIGITS  = 3'd1,
      PS_BODY    = 3'd2,
      PS_CR1     = 3'd3,
      PS_CRLF    = 3'd4,
      PS_CRLFCR  = 3'd5,
      PS_PAYLOAD = 3'd6
   } parse_state_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] payload_byte;
      logic              last_byte;
      logic              empty_frame;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

   // Lower- and upper-case header character at one position.
   function automatic logic [2*BYTE_W-1:0] hdr_chars(input logic [POS_W-1:0] pos);
      logic [2*BYTE_W-1:0] chars;
      case (pos)
         4'd0:    chars = {"c", "C"};
         4'd1:    chars = {"o", "O"};
         4'd2:    chars = {"n", "N"};
         4'd3:    chars = {"t", "T"};
         4'd4:    chars = {"e", "E"};
         4'd5:    chars = {"n", "N"};
         4'd6:    chars = {"t", "T"};
         4'd7:    chars = {"-", "-"};
         4'd8:    chars = {"l", "L"};
         4'd9:    chars = {"e", "E"};
         4'd10:   chars = {"n", "N"};
         4'd11:   chars = {"g", "G"};
         4'd12:   chars = {"t", "T"};
         4'd13:   chars = {"h", "H"};
         4'd14:   chars = {":", ":"};
         default: chars = '0;
      endcase
      return chars;
   endfunction

   function automatic logic hdr_match(input logic [POS_W-1:0] pos,
                                      input logic [BYTE_W-1:0] c);
      logic [2*BYTE_W-1:0] chars;
      chars = hdr_chars(pos);
      return (pos <= HDR_LAST_POS) &&
             ((c == chars[2*BYTE_W-1:BYTE_W]) || (c == chars[BYTE_W-1:0]));
   endfunction

endpackage

// File: rtl/clfe_parser.sv
// Byte parser: header match, length digits, CR LF CR LF search and payload count.
// Holds the parse state; uses clfe_pkg for types, constants and header lookup.
module clfe_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [clfe_pkg::BYTE_W-1:0]   stream_byte,
   input  logic [clfe_pkg::LEN_W-1:0]    max_length,
   output clfe_pkg::result_type          result
);

   clfe_pkg::parse_state_type state_ff, state_in;
   logic [clfe_pkg::POS_W-1:0] hdr_pos_ff, hdr_pos_in;
   logic [clfe_pkg::ACC_W-1:0] remaining_ff, remaining_in;
   logic [clfe_pkg::LEN_W-1:0] count_ff, count_in;

   logic                       is_digit;
   logic [3:0]                 digit;
   logic [clfe_pkg::ACC_W-1:0] acc_limit;
   logic [clfe_pkg::ACC_W+3:0] acc_times10;
   logic [clfe_pkg::LEN_W-1:0] count_inc;

   assign is_digit    = (stream_byte >= clfe_pkg::CH_ZERO) && (stream_byte <= clfe_pkg::CH_NINE);
   assign digit       = stream_byte[3:0];
   assign acc_limit   = (digit <= 4'd5) ? clfe_pkg::ACC_LIM_LO : clfe_pkg::ACC_LIM_HI;
   assign acc_times10 = ({4'd0, remaining_ff} << 3) + ({4'd0, remaining_ff} << 1)
                        + {{(clfe_pkg::ACC_W){1'b0}}, digit};
   assign count_inc   = count_ff + clfe_pkg::LEN_W'(1);

   // next state
   always_comb begin
      state_in   = state_ff;
      hdr_pos_in = '0;
      unique case (state_ff)
         clfe_pkg::PS_HEADER: begin
            if (clfe_pkg::hdr_match(hdr_pos_ff, stream_byte)) begin
               if (hdr_pos_ff == clfe_pkg::HDR_LAST_POS) begin
                  state_in = clfe_pkg::PS_DIGITS;
               end else begin
                  hdr_pos_in = hdr_pos_ff + clfe_pkg::POS_W'(1);
               end
            end
         end
         clfe_pkg::PS_DIGITS: begin
            if (!is_digit && stream_byte != clfe_pkg::CH_SP) begin
               state_in = (remaining_ff > {4'd0, max_length}) ? clfe_pkg::PS_HEADER
                                                               : clfe_pkg::PS_BODY;
            end
         end
         clfe_pkg::PS_BODY: begin
            if (stream_byte == clfe_pkg::CH_CR) state_in = clfe_pkg::PS_CR1;
         end
         clfe_pkg::PS_CR1: begin
            if (stream_byte == clfe_pkg::CH_LF) state_in = clfe_pkg::PS_CRLF;
            else if (stream_byte != clfe_pkg::CH_CR) state_in = clfe_pkg::PS_BODY;
         end
         clfe_pkg::PS_CRLF: begin
            state_in = (stream_byte == clfe_pkg::CH_CR) ? clfe_pkg::PS_CRLFCR
                                                        : clfe_pkg::PS_BODY;
         end
         clfe_pkg::PS_CRLFCR: begin
            if (stream_byte == clfe_pkg::CH_LF) state_in = clfe_pkg::PS_PAYLOAD;
            else if (stream_byte == clfe_pkg::CH_CR) state_in = clfe_pkg::PS_CR1;
            else state_in = clfe_pkg::PS_BODY;
         end
         clfe_pkg::PS_PAYLOAD: begin
            if (remaining_ff <= clfe_pkg::ACC_W'(1)) state_in = clfe_pkg::PS_HEADER;
         end
         default: state_in = clfe_pkg::PS_HEADER;
      endcase
   end

   // length accumulator and payload counter
   always_comb begin
      remaining_in = remaining_ff;
      count_in     = count_ff;
      case (state_ff)
         clfe_pkg::PS_HEADER: begin
            if (clfe_pkg::hdr_match(hdr_pos_ff, stream_byte) &&
                hdr_pos_ff == clfe_pkg::HDR_LAST_POS) begin
               remaining_in = '0;
            end
         end
         clfe_pkg::PS_DIGITS: begin
            if (is_digit) begin
               remaining_in = (remaining_ff > acc_limit) ? clfe_pkg::ACC_SAT
                                                         : acc_times10[clfe_pkg::ACC_W-1:0];
            end
         end
         clfe_pkg::PS_CRLFCR: begin
            if (stream_byte == clfe_pkg::CH_LF) count_in = '0;
         end
         clfe_pkg::PS_PAYLOAD: begin
            if (remaining_ff == '0) begin
               count_in = '0;
            end else begin
               remaining_in = remaining_ff - clfe_pkg::ACC_W'(1);
               count_in     = (remaining_ff == clfe_pkg::ACC_W'(1)) ? '0 : count_inc;
            end
         end
         default: ;
      endcase
   end

   // result
   always_comb begin
      result = '0;
      if (state_ff == clfe_pkg::PS_PAYLOAD) begin
         result.valid = 1'b1;
         if (remaining_ff == '0) begin
            result.last_byte   = 1'b1;
            result.empty_frame = 1'b1;
         end else begin
            result.payload_byte = stream_byte;
            if (remaining_ff == clfe_pkg::ACC_W'(1)) begin
               result.last_byte    = 1'b1;
               result.frame_length = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clfe_pkg::PS_HEADER;
         hdr_pos_ff   <= '0;
         remaining_ff <= '0;
         count_ff     <= '0;
      end else if (step) begin
         state_ff     <= state_in;
         hdr_pos_ff   <= hdr_pos_in;
         remaining_ff <= remaining_in;
         count_ff     <= count_in;
      end
   end

endmodule

// File: rtl/content_length_frame_extractor.sv
// Top level of the content-length frame extractor: input register, parser, result register.
// Depends on clfe_pkg and clfe_parser.
//
// Usage:
//   req_* carries one stream byte per item (valid/ready). The block looks for a
//   "content-length:" header (each letter in either case), reads the decimal
//   length with optional spaces, waits for CR LF CR LF and then returns the next
//   length bytes as rsp_* items, the last one flagged with the frame length.
//   A zero length returns one empty-frame item in place of the byte after the
//   blank line. Lengths above max_length drop the parser back to header search.
//   csr_write_enable/csr_write_data set max_length; write it only while idle.
//   Path: the accepting edge loads a byte into the input register; the parser
//   result for it is loaded into the result register when the byte advances,
//   and then shows up on rsp_*. Throughput: one byte per cycle while rsp_* is
//   not stalled; the parser state update is a single short step per byte.
//   Stalls: while rsp_ready is low with a result pending, the input register
//   still takes one more byte, then req_ready drops until the result is taken.
//   Reset: synchronous; clears both valid flags, the parse state and sets
//   max_length to 100000.
module content_length_frame_extractor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [clfe_pkg::BYTE_W-1:0] req_stream_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [clfe_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic                        rsp_last_byte,
   output logic                        rsp_empty_frame,
   output logic [clfe_pkg::LEN_W-1:0]  rsp_frame_length,
   input  logic                        csr_write_enable,
   input  logic [clfe_pkg::LEN_W-1:0]  csr_write_data
);

   logic                        in_valid_ff, in_valid_in;
   logic [clfe_pkg::BYTE_W-1:0] in_byte_ff;
   logic [clfe_pkg::LEN_W-1:0]  max_length_ff;
   logic                        out_valid_ff, out_valid_in;
   clfe_pkg::result_type        out_ff;
   clfe_pkg::result_type        result;
   logic                        advance;
   logic                        req_take;

   // Advance the held byte when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   clfe_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .max_length  (max_length_ff),
      .result      (result)
   );

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance) begin
         out_valid_in = result.valid;   // bytes with no result just drop out
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control flags and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         max_length_ff <= clfe_pkg::MAX_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) max_length_ff <= csr_write_data;
      end
   end

   // Payload registers: load only, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_stream_byte;
      if (advance && result.valid) out_ff <= result;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_last_byte    = out_ff.last_byte;
   assign rsp_empty_frame  = out_ff.empty_frame;
   assign rsp_frame_length = out_ff.frame_length;

   // An empty frame is always a closing item with zero payload and length.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |->
         rsp_last_byte && rsp_payload_byte == '0 && rsp_frame_length == '0)
      else $error("empty frame item malformed");

   // Only the closing item carries a length.
   a_len_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |-> rsp_frame_length == '0)
      else $error("frame length on non-final item");

   // A closing data byte always reports a nonzero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte && !rsp_empty_frame |-> rsp_frame_length != '0)
      else $error("zero length on final data byte");

   // A result waiting on the receiver blocks the parser from advancing.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("parser advanced over stalled result");

endmodule
